FILE: rtl/gpiol_pkg.sv
package gpiol_pkg;

  // Reset value of both configuration words: every pin a floating input
  localparam logic [31:0] CFG_RESET = 32'h4444_4444;

  localparam int unsigned NUM_PINS     = 16;
  localparam int unsigned PINS_PER_CFG = 8;
  localparam int unsigned NIBBLE_W     = 4;

  // Bit of the lock register that carries the key
  localparam int unsigned KEY_BIT = 16;

  // Register map
  typedef enum logic [2:0] {
    REG_CFGLOW  = 3'd0,
    REG_CFGHIGH = 3'd1,
    REG_INPUT   = 3'd2,
    REG_OUTPUT  = 3'd3,
    REG_SETRST  = 3'd4,
    REG_RST     = 3'd5,
    REG_LOCK    = 3'd6
  } reg_index_t;

  // Lock key sequence, one-hot
  typedef enum logic [3:0] {
    SEQ_IDLE  = 4'b0001,
    SEQ_ONE   = 4'b0010,
    SEQ_ZERO  = 4'b0100,
    SEQ_ARMED = 4'b1000
  } key_seq_t;

  // One bus access
  typedef struct packed {
    logic        wr;
    logic [2:0]  idx;
    logic [31:0] data;
    logic [15:0] pins;
  } access_t;

  // One result: port state after the access
  typedef struct packed {
    logic [31:0] read_data;
    logic [15:0] output_levels;
    logic [31:0] pin_config_low;
    logic [31:0] pin_config_high;
    logic        port_locked;
  } result_t;

endpackage

FILE: rtl/gpio_port_with_config_lock.sv
// 16-pin GPIO port with configuration lock, one register access per transfer.
// Each access passes through the input register, then the result register;
// decode and update sit between them.
// Throughput: one access per cycle, limited only by the output side.
// Reset (rst, synchronous, active high): config words 0x44444444, output
// data, lock bits and lock key cleared, key sequence idle; both stages empty.
module gpio_port_with_config_lock (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [47:0]  s_tdata,   // [31:0] write_data, [47:32] pin_levels
  input  logic [3:0]   s_tuser,   // [0] req_type, [3:1] reg_index
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [119:0] m_tdata    // [31:0] read_data, [47:32] output_levels,
                                  // [79:48] pin_config_low,
                                  // [111:80] pin_config_high,
                                  // [112] port_locked, [119:113] zero
);
  import gpiol_pkg::*;

  access_t in_acc;
  access_t acc;
  result_t res;
  result_t out_res;
  logic    acc_fire;
  logic    out_free;

  // Unpack slave transfer
  assign in_acc.wr   = s_tuser[0];
  assign in_acc.idx  = s_tuser[3:1];
  assign in_acc.data = s_tdata[31:0];
  assign in_acc.pins = s_tdata[47:32];

  gpiol_in_stage u_in (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .in_acc   (in_acc),
    .out_free (out_free),
    .acc_fire (acc_fire),
    .acc      (acc)
  );

  gpiol_regs u_regs (
    .clk      (clk),
    .rst      (rst),
    .acc_fire (acc_fire),
    .acc      (acc),
    .res      (res)
  );

  gpiol_out_stage u_out (
    .clk       (clk),
    .rst       (rst),
    .acc_fire  (acc_fire),
    .res       (res),
    .out_free  (out_free),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_res   (out_res)
  );

  // Pack master transfer
  assign m_tdata = {7'd0, out_res.port_locked, out_res.pin_config_high,
                    out_res.pin_config_low, out_res.output_levels,
                    out_res.read_data};

endmodule

FILE: rtl/gpiol_in_stage.sv
module gpiol_in_stage (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  gpiol_pkg::access_t in_acc,
  input  logic               out_free,
  output logic               acc_fire,
  output gpiol_pkg::access_t acc
);
  import gpiol_pkg::*;

  logic    valid;
  access_t item;

  // Held access moves on when the result register can take its result
  assign acc_fire = valid && out_free;
  assign in_ready = !valid || acc_fire;
  assign acc      = item;

  // Valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
  end

  // Access payload
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item <= in_acc;
    end
  end

endmodule

FILE: rtl/gpiol_regs.sv
module gpiol_regs (
  input  logic               clk,
  input  logic               rst,
  input  logic               acc_fire,
  input  gpiol_pkg::access_t acc,
  output gpiol_pkg::result_t res
);
  import gpiol_pkg::*;

  logic [31:0] cfg_low,   cfg_low_next;
  logic [31:0] cfg_high,  cfg_high_next;
  logic [15:0] out_data,  out_data_next;
  logic [15:0] lock_bits, lock_bits_next;
  logic        lock_key,  lock_key_next;
  key_seq_t    seq,       seq_next;

  logic [31:0] mask_low, mask_high;
  logic [31:0] rd;
  logic [15:0] low_half;
  logic        key_in;
  logic        bits_match;

  // Writable nibbles: a pin is frozen when locked and its lock bit is set
  always_comb begin
    for (int i = 0; i < PINS_PER_CFG; i++) begin
      mask_low[i*NIBBLE_W +: NIBBLE_W]  = {NIBBLE_W{!(lock_key && lock_bits[i])}};
      mask_high[i*NIBBLE_W +: NIBBLE_W] =
        {NIBBLE_W{!(lock_key && lock_bits[i + PINS_PER_CFG])}};
    end
  end

  assign low_half   = acc.data[15:0];
  assign key_in     = acc.data[KEY_BIT];
  assign bits_match = (low_half == lock_bits);

  // Access decode and next state
  always_comb begin
    cfg_low_next   = cfg_low;
    cfg_high_next  = cfg_high;
    out_data_next  = out_data;
    lock_bits_next = lock_bits;
    lock_key_next  = lock_key;
    seq_next       = seq;
    rd             = '0;
    if (acc.wr) begin
      case (acc.idx)
        REG_CFGLOW: begin
          cfg_low_next = (cfg_low & ~mask_low) | (acc.data & mask_low);
        end
        REG_CFGHIGH: begin
          cfg_high_next = (cfg_high & ~mask_high) | (acc.data & mask_high);
        end
        REG_OUTPUT: begin
          out_data_next = low_half;
        end
        REG_SETRST: begin
          // set half wins over reset half
          out_data_next = (out_data & ~acc.data[31:16]) | low_half;
        end
        REG_RST: begin
          out_data_next = out_data & ~low_half;
        end
        REG_LOCK: begin
          if (!lock_key) begin
            if (seq == SEQ_ONE && !key_in && bits_match) begin
              seq_next = SEQ_ZERO;
            end else if (seq == SEQ_ZERO && key_in && bits_match) begin
              seq_next = SEQ_ARMED;
            end else begin
              // abort or fresh start
              lock_bits_next = low_half;
              seq_next       = key_in ? SEQ_ONE : SEQ_IDLE;
            end
          end
        end
        default: begin
        end
      endcase
    end else begin
      case (acc.idx)
        REG_CFGLOW:  rd = cfg_low;
        REG_CFGHIGH: rd = cfg_high;
        REG_INPUT:   rd = {16'd0, acc.pins};
        REG_OUTPUT:  rd = {16'd0, out_data};
        REG_LOCK: begin
          rd = {15'd0, lock_key, lock_bits};
          if (!lock_key) begin
            if (seq == SEQ_ARMED) begin
              lock_key_next = 1'b1;
            end
            seq_next = SEQ_IDLE;
          end
        end
        default: rd = '0;
      endcase
    end
  end

  // Result of this access, port state after it
  assign res.read_data       = rd;
  assign res.output_levels   = out_data_next;
  assign res.pin_config_low  = cfg_low_next;
  assign res.pin_config_high = cfg_high_next;
  assign res.port_locked     = lock_key_next;

  // Architectural registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_low   <= CFG_RESET;
      cfg_high  <= CFG_RESET;
      out_data  <= '0;
      lock_bits <= '0;
      lock_key  <= 1'b0;
      seq       <= SEQ_IDLE;
    end else if (acc_fire) begin
      cfg_low   <= cfg_low_next;
      cfg_high  <= cfg_high_next;
      out_data  <= out_data_next;
      lock_bits <= lock_bits_next;
      lock_key  <= lock_key_next;
      seq       <= seq_next;
    end
  end

  // Lock is sticky until reset
  a_lock_sticky: assert property (@(posedge clk) disable iff (rst)
    lock_key |=> lock_key)
    else $error("port lock dropped without reset");

  // Lock bits frozen once locked
  a_lock_bits_frozen: assert property (@(posedge clk) disable iff (rst)
    lock_key |=> $stable(lock_bits))
    else $error("lock bits changed while locked");

  // Lock only taken from the armed state
  a_lock_from_armed: assert property (@(posedge clk) disable iff (rst)
    $rose(lock_key) |-> $past(seq == SEQ_ARMED))
    else $error("lock taken outside armed state");

  // Nibble of pin 0 holds while that pin is locked
  a_pin0_frozen: assert property (@(posedge clk) disable iff (rst)
    lock_key && lock_bits[0] |=> $stable(cfg_low[3:0]))
    else $error("locked pin configuration changed");

endmodule

FILE: rtl/gpiol_out_stage.sv
module gpiol_out_stage (
  input  logic               clk,
  input  logic               rst,
  input  logic               acc_fire,
  input  gpiol_pkg::result_t res,
  output logic               out_free,
  output logic               out_valid,
  input  logic               out_ready,
  output gpiol_pkg::result_t out_res
);
  import gpiol_pkg::*;

  logic    valid;
  result_t held;

  assign out_free  = !valid || out_ready;
  assign out_valid = valid;
  assign out_res   = held;

  // Valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (out_free) begin
      valid <= acc_fire;
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (acc_fire) begin
      held <= res;
    end
  end

endmodule
